[rtl/bpa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Field widths, item kinds, result status codes and map word geometry.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned CNT_W    = 13;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  // Map word: one byte of used bits
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned BYTE_SH = $clog2(BYTE_W);
  localparam int unsigned POP_W   = $clog2(BYTE_W + 1);
  localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;

  localparam logic REG_RESERVED = 1'b0;
  localparam logic [CNT_W-1:0] RESERVED_RST = 13'd256;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_INIT  = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

endpackage
`default_nettype wire

[rtl/bitmap_page_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap page allocator
// First-fit physical page allocator over a used-bit map with a used count.
// ----------------------------------------------------------------------------
// Command channel: an item (kind_i, address_i, page_count_i) is taken on a
// clock edge with start high and busy low. Each item gives one result beat
// on status_o, start_address_o and used_total_o, marked by result_valid_o for
// a single cycle; the receiver cannot stall it, busy is low in that cycle.
// The map sits in a byte-wide RAM of NB = ceil(PAGES/8) words; one byte is
// read, tested or rewritten a cycle by a single shared datapath. Work per
// item, the result beat following in the next cycle:
//   init     : one write a byte over all NB bytes.
//   allocate : first-fit scan of the bytes up to the hit, then a rewrite of
//              the bytes spanned to mark the run; a miss scans all NB bytes.
//   free     : a check, then a rewrite of the bytes spanned to clear the run.
//   zero page counts on allocate or free, a free at address zero and kind
//   three answer in the cycle after the beat without going busy; a free span
//   past the last page answers after the check. One item at a time.
// PAGE_BYTES must be a power of two, which the block does not check, so the
// page of an address is a plain shift. Reset runs a clearing pass over all
// NB words (busy high, no result); configuration writes over the APB port are taken at any time.
// ----------------------------------------------------------------------------
module bitmap_page_allocator #(
  parameter int unsigned PAGES      = 4096,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpa_pkg::APB_AW-1:0]   paddr,
  input  logic [bpa_pkg::APB_DW-1:0]   pwdata,
  output logic [bpa_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  input  logic                         start,
  output logic                         busy,
  input  logic [bpa_pkg::KIND_W-1:0]   kind_i,
  input  logic [bpa_pkg::ADDR_W-1:0]   address_i,
  input  logic [bpa_pkg::CNT_W-1:0]    page_count_i,
  output logic                         result_valid_o,
  output logic [bpa_pkg::STATUS_W-1:0] status_o,
  output logic [bpa_pkg::ADDR_W-1:0]   start_address_o,
  output logic [bpa_pkg::CNT_W-1:0]    used_total_o
);
  import bpa_pkg::*;

  localparam int unsigned NB    = (PAGES + BYTE_W - 1) / BYTE_W;
  localparam int unsigned BAW   = (NB > 1) ? $clog2(NB) : 1;
  localparam int unsigned BPW   = $clog2(NB + 1);
  localparam int unsigned PXW   = $clog2(PAGES + BYTE_W);
  localparam int unsigned CW    = $clog2(PAGES + 1);
  localparam int unsigned PBW   = $clog2(PAGE_BYTES);
  localparam int unsigned SUM_W = ADDR_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_CHK,
    S_SCAN,
    S_RMW
  } state_e;

  state_e            state_q;
  logic              emit_q;
  logic [CNT_W-1:0]  n_q;
  logic [ADDR_W-1:0] addr_q;
  logic [CW-1:0]     cnt_q;
  logic [CW-1:0]     lim_q;
  logic [CNT_W-1:0]  resv_q;
  logic [BPW-1:0]    ptr_q;
  logic [BPW-1:0]    end_q;
  logic [BAW-1:0]    pa_q;
  logic              dv_q;
  logic [CNT_W-1:0]  run_q;
  logic [PXW-1:0]    rs_q;
  logic [PXW-1:0]    lo_q;
  logic [PXW-1:0]    hi_q;
  logic              alloc_q;
  logic              rv_q;
  status_e           st_q;
  logic [ADDR_W-1:0] sa_q;

  logic [BYTE_W-1:0] rdata;
  logic              ram_we;
  logic [BAW-1:0]    ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;

  // shared byte datapath
  logic [PXW-1:0]    base;
  logic [PXW-1:0]    fbase;
  logic [BYTE_W-1:0] fill_w;
  logic [BYTE_W-1:0] span_m;
  logic [BYTE_W-1:0] mod_w;
  logic [POP_W-1:0]  freed;
  logic              hit;
  logic [PXW-1:0]    hit_start;
  logic [CNT_W-1:0]  run_n;
  logic [PXW-1:0]    rs_n;
  logic [PXW-1:0]    alloc_hi;
  logic [ADDR_W-1:0] first_pg;
  logic [PXW-1:0]    free_lo;
  logic [PXW-1:0]    free_hi;
  logic              free_oob;
  logic [CW-1:0]     lim_v;
  logic              scan_more;
  logic              rmw_more;
  logic              cfg_we;

  always_comb begin
    logic [PXW-1:0]   p;
    logic             u;
    logic [CNT_W-1:0] r;
    logic [PXW-1:0]   s;
    logic             f;
    logic [PXW-1:0]   fs;
    base   = PXW'(pa_q) << BYTE_SH;
    fbase  = PXW'(ptr_q) << BYTE_SH;
    r      = run_q;
    s      = rs_q;
    f      = 1'b0;
    fs     = rs_q;
    freed  = '0;
    fill_w = '0;
    span_m = '0;
    for (int b = 0; b < BYTE_W; b++) begin
      p         = base + PXW'(b);
      fill_w[b] = (fbase + PXW'(b)) < PXW'(lim_q);
      span_m[b] = (p >= lo_q) && (p <= hi_q);
      freed     = freed + POP_W'(rdata[b] & span_m[b]);
      u         = rdata[b] || (ADDR_W'(p) >= ADDR_W'(PAGES));
      if (!f) begin
        if (!u) begin
          r = r + 1'b1;
          if (r == n_q) begin
            f  = 1'b1;
            fs = s;
          end
        end else begin
          s = p + 1'b1;
          r = '0;
        end
      end
    end
    hit       = f;
    hit_start = fs;
    run_n     = r;
    rs_n      = s;
    mod_w     = alloc_q ? (rdata | span_m) : (rdata & ~span_m);
  end

  assign alloc_hi  = PXW'(ADDR_W'(hit_start) + ADDR_W'(n_q) - 1'b1);
  assign first_pg  = addr_q >> PBW;
  assign free_lo   = PXW'(first_pg);
  assign free_hi   = PXW'(first_pg + ADDR_W'(n_q) - 1'b1);
  assign free_oob  = (SUM_W'(first_pg) + SUM_W'(n_q)) > SUM_W'(PAGES);
  assign lim_v     = (ADDR_W'(resv_q) > ADDR_W'(PAGES)) ? CW'(PAGES) : CW'(resv_q);
  assign scan_more = ptr_q < BPW'(NB);
  assign rmw_more  = ptr_q <= end_q;

  assign ram_re    = ((state_q == S_SCAN) && scan_more) || ((state_q == S_RMW) && rmw_more);
  assign ram_we    = (state_q == S_FILL) || ((state_q == S_RMW) && dv_q);
  assign ram_waddr = (state_q == S_FILL) ? ptr_q[BAW-1:0] : pa_q;
  assign ram_wdata = (state_q == S_FILL) ? fill_w : mod_w;

  bpa_map_ram #(
    .DEPTH (NB),
    .AW    (BAW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ptr_q[BAW-1:0]),
    .rdata_o (rdata)
  );

  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_RESERVED);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RESERVED) ? APB_DW'(resv_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_FILL;
      emit_q  <= 1'b0;
      n_q     <= '0;
      addr_q  <= '0;
      cnt_q   <= '0;
      lim_q   <= '0;
      resv_q  <= RESERVED_RST;
      ptr_q   <= '0;
      end_q   <= '0;
      pa_q    <= '0;
      dv_q    <= 1'b0;
      run_q   <= '0;
      rs_q    <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      alloc_q <= 1'b0;
      rv_q    <= 1'b0;
      st_q    <= ST_DONE;
      sa_q    <= '0;
    end else begin
      rv_q <= 1'b0;
      if (cfg_we) begin
        resv_q <= pwdata[CNT_W-1:0];
      end
      case (state_q)
        S_IDLE: begin
          if (start) begin
            n_q    <= page_count_i;
            addr_q <= address_i;
            ptr_q  <= '0;
            dv_q   <= 1'b0;
            run_q  <= '0;
            rs_q   <= '0;
            case (kind_i)
              KIND_INIT: begin
                lim_q   <= lim_v;
                cnt_q   <= lim_v;
                emit_q  <= 1'b1;
                state_q <= S_FILL;
              end
              KIND_ALLOC: begin
                if (page_count_i == '0) begin
                  rv_q <= 1'b1;
                  st_q <= ST_INVALID;
                  sa_q <= '0;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              KIND_FREE: begin
                if ((address_i == '0) || (page_count_i == '0)) begin
                  rv_q <= 1'b1;
                  st_q <= ST_INVALID;
                  sa_q <= '0;
                end else begin
                  state_q <= S_CHK;
                end
              end
              default: begin
                rv_q <= 1'b1;
                st_q <= ST_INVALID;
                sa_q <= '0;
              end
            endcase
          end
        end
        S_FILL: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q == BPW'(NB - 1)) begin
            state_q <= S_IDLE;
            emit_q  <= 1'b0;
            if (emit_q) begin
              rv_q <= 1'b1;
              st_q <= ST_DONE;
              sa_q <= '0;
            end
          end
        end
        S_CHK: begin
          if (free_oob) begin
            rv_q    <= 1'b1;
            st_q    <= ST_INVALID;
            sa_q    <= '0;
            state_q <= S_IDLE;
          end else begin
            lo_q    <= free_lo;
            hi_q    <= free_hi;
            ptr_q   <= BPW'(free_lo >> BYTE_SH);
            end_q   <= BPW'(free_hi >> BYTE_SH);
            alloc_q <= 1'b0;
            dv_q    <= 1'b0;
            state_q <= S_RMW;
          end
        end
        S_SCAN: begin
          if (scan_more) begin
            ptr_q <= ptr_q + 1'b1;
            pa_q  <= ptr_q[BAW-1:0];
          end
          dv_q <= scan_more;
          if (dv_q) begin
            run_q <= run_n;
            rs_q  <= rs_n;
            if (hit) begin
              lo_q    <= hit_start;
              hi_q    <= alloc_hi;
              cnt_q   <= cnt_q + CW'(n_q);
              ptr_q   <= BPW'(hit_start >> BYTE_SH);
              end_q   <= BPW'(alloc_hi >> BYTE_SH);
              alloc_q <= 1'b1;
              dv_q    <= 1'b0;
              state_q <= S_RMW;
            end
          end else if (!scan_more) begin
            rv_q    <= 1'b1;
            st_q    <= ST_NOSPACE;
            sa_q    <= '0;
            state_q <= S_IDLE;
          end
        end
        S_RMW: begin
          if (rmw_more) begin
            ptr_q <= ptr_q + 1'b1;
            pa_q  <= ptr_q[BAW-1:0];
          end
          dv_q <= rmw_more;
          if (dv_q) begin
            if (!alloc_q) begin
              cnt_q <= cnt_q - CW'(freed);
            end
          end else if (!rmw_more) begin
            rv_q    <= 1'b1;
            st_q    <= ST_DONE;
            sa_q    <= alloc_q ? (ADDR_W'(lo_q) << PBW) : '0;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign result_valid_o  = rv_q;
  assign status_o        = st_q;
  assign start_address_o = sa_q;
  assign used_total_o    = CNT_W'(cnt_q);

  a_beat_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || result_valid_o))
    else $error("accepted beat neither started work nor answered");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobed while still busy");

  a_result_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o || $past(start))
    else $error("result strobe held without a new beat");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(PAGES))
    else $error("used count beyond page total");

  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o != ST_DONE)) |-> (start_address_o == '0))
    else $error("address reported on a failed request");

endmodule
`default_nettype wire

[rtl/bpa_map_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Page map RAM
// One write port and one registered read port, one byte of used bits a word.
// ----------------------------------------------------------------------------
module bpa_map_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [bpa_pkg::BYTE_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [bpa_pkg::BYTE_W-1:0] rdata_o
);
  import bpa_pkg::*;

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire
